[src/firlc_pkg.sv]
`timescale 1ns / 1ps

package firlc_pkg;

    localparam int TAPS        = 100;
    localparam int SAMPLE_BITS = 16;
    localparam int COEF_BITS   = 16;
    localparam int FRAC_BITS   = 15;
    localparam int IDX_W       = $clog2(TAPS);
    localparam int PROD_W      = SAMPLE_BITS + COEF_BITS;
    localparam int ACC_W       = PROD_W + $clog2(TAPS) + 1;

    localparam logic ACT_COEF   = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

    typedef struct packed {
        logic                        action;
        logic [6:0]                  coef_index;
        logic signed [COEF_BITS-1:0] coef_value;
        logic signed [15:0]          sample;
    } item_t;

    typedef struct packed {
        logic signed [15:0] filtered;
        logic               clipped;
    } result_t;

    typedef struct packed {
        logic clear;
        logic mul_en;
        logic acc_en;
    } mac_ctrl_t;

endpackage

[src/firlc_mac.sv]
`timescale 1ns / 1ps

module firlc_mac
    import firlc_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  mac_ctrl_t                     ctrl,
    input  logic signed [COEF_BITS-1:0]   coef,
    input  logic signed [SAMPLE_BITS-1:0] tap,
    output logic signed [SAMPLE_BITS-1:0] filtered,
    output logic                          clipped
);

    localparam int Y_W = ACC_W - FRAC_BITS;
    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [Y_W-1:0]   SAT_HI = Y_W'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [Y_W-1:0]   SAT_LO = ~SAT_HI;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  rnd;
    logic signed [ACC_W-1:0]  shifted;
    logic signed [Y_W-1:0]    y_full;

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= coef * tap;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else if (ctrl.clear)
        begin
            acc_reg <= '0;
        end
        else if (ctrl.acc_en)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    // Adding one half and shifting arithmetically rounds halves upwards.
    always_comb
    begin
        rnd     = acc_reg + HALF;
        shifted = rnd >>> FRAC_BITS;
        y_full  = shifted[Y_W-1:0];
        if (y_full > SAT_HI)
        begin
            filtered = SAT_HI[SAMPLE_BITS-1:0];
            clipped  = 1'b1;
        end
        else if (y_full < SAT_LO)
        begin
            filtered = SAT_LO[SAMPLE_BITS-1:0];
            clipped  = 1'b1;
        end
        else
        begin
            filtered = y_full[SAMPLE_BITS-1:0];
            clipped  = 1'b0;
        end
    end

endmodule

[src/fir_filter_loaded_coefficients.sv]
`timescale 1ns / 1ps

// Direct-form FIR filter with 100 loadable Q1.15 taps over signed 16-bit samples.
// A word with action 0 writes one coefficient and gives no result;
// an index beyond the last tap is ignored. A word with action 1 gives one result,
// formed from the delay line before the new sample enters it, so the output lags by
// one sample. A sample word keeps the block busy while the single multiplier and
// accumulator step through one tap per cycle, reading the coefficient and delay
// memories once each per tap. The next word may be accepted while a finished
// result still waits to be taken.
module fir_filter_loaded_coefficients
    import firlc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    state_t state_reg;

    logic [IDX_W-1:0] cnt_reg;
    logic [IDX_W-1:0] rd_ptr_reg;
    logic [IDX_W-1:0] wr_ptr_reg;
    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic    rd_vld_reg;
    logic    mul_vld_reg;
    logic    result_valid_reg;
    result_t result_reg;

    logic signed [COEF_BITS-1:0]   coef_mem [TAPS];
    logic signed [SAMPLE_BITS-1:0] dly_mem  [TAPS];
    logic [TAPS-1:0] coef_vld_reg;
    logic [TAPS-1:0] dly_vld_reg;

    logic signed [COEF_BITS-1:0]   coef_rd_reg;
    logic signed [SAMPLE_BITS-1:0] dly_rd_reg;
    logic coef_ok_reg;
    logic dly_ok_reg;

    logic accept;
    logic coef_wr;
    logic slot_free;
    logic dly_wr;
    mac_ctrl_t mac_ctrl;
    logic signed [COEF_BITS-1:0]   mac_coef;
    logic signed [SAMPLE_BITS-1:0] mac_tap;
    logic signed [SAMPLE_BITS-1:0] mac_y;
    logic mac_clip;

    assign item_stall   = (state_reg != ST_IDLE);
    assign accept       = item_valid && !item_stall;
    assign coef_wr      = accept && (item.action == ACT_COEF) && (32'(item.coef_index) < TAPS);
    assign slot_free    = !result_valid_reg || !result_stall;
    assign dly_wr       = (state_reg == ST_FINISH) && slot_free;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Entries never written read as zero through their valid bits.
    assign mac_coef = coef_ok_reg ? coef_rd_reg : '0;
    assign mac_tap  = dly_ok_reg ? dly_rd_reg : '0;

    assign mac_ctrl.clear  = accept && (item.action == ACT_SAMPLE);
    assign mac_ctrl.mul_en = rd_vld_reg;
    assign mac_ctrl.acc_en = mul_vld_reg;

    always_ff @(posedge clk)
    begin
        if (coef_wr)
        begin
            coef_mem[IDX_W'(item.coef_index)] <= item.coef_value;
        end
        if (dly_wr)
        begin
            dly_mem[wr_ptr_reg] <= sample_reg;
        end
        coef_rd_reg <= coef_mem[cnt_reg];
        dly_rd_reg  <= dly_mem[rd_ptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_vld_reg <= '0;
            dly_vld_reg  <= '0;
            coef_ok_reg  <= 1'b0;
            dly_ok_reg   <= 1'b0;
        end
        else
        begin
            if (coef_wr)
            begin
                coef_vld_reg[IDX_W'(item.coef_index)] <= 1'b1;
            end
            if (dly_wr)
            begin
                dly_vld_reg[wr_ptr_reg] <= 1'b1;
            end
            coef_ok_reg <= coef_vld_reg[cnt_reg];
            dly_ok_reg  <= dly_vld_reg[rd_ptr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            cnt_reg          <= '0;
            rd_ptr_reg       <= '0;
            wr_ptr_reg       <= '0;
            sample_reg       <= '0;
            rd_vld_reg       <= 1'b0;
            mul_vld_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            rd_vld_reg  <= (state_reg == ST_RUN);
            mul_vld_reg <= rd_vld_reg;
            if (dly_wr)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_valid_reg && !result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept && (item.action == ACT_SAMPLE))
                    begin
                        sample_reg <= item.sample;
                        cnt_reg    <= '0;
                        rd_ptr_reg <= wr_ptr_reg;
                        state_reg  <= ST_RUN;
                    end
                end
                ST_RUN:
                begin
                    cnt_reg    <= cnt_reg + 1'b1;
                    rd_ptr_reg <= (rd_ptr_reg == IDX_W'(TAPS - 1)) ? '0 : rd_ptr_reg + 1'b1;
                    if (cnt_reg == IDX_W'(TAPS - 1))
                    begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    if (!rd_vld_reg && !mul_vld_reg)
                    begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH:
                begin
                    if (slot_free)
                    begin
                        result_reg.filtered <= mac_y;
                        result_reg.clipped  <= mac_clip;
                        wr_ptr_reg <= (wr_ptr_reg == IDX_W'(TAPS - 1)) ? '0 : wr_ptr_reg + 1'b1;
                        state_reg  <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    firlc_mac u_mac (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (mac_ctrl),
        .coef     (mac_coef),
        .tap      (mac_tap),
        .filtered (mac_y),
        .clipped  (mac_clip)
    );

    a_pipe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_vld_reg || mul_vld_reg) |-> (state_reg == ST_RUN || state_reg == ST_DRAIN))
        else $error("Tap pipeline active outside a sample pass.");

    a_sample_start: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.action == ACT_SAMPLE) |=> (state_reg == ST_RUN && cnt_reg == '0))
        else $error("Sample word did not start a tap pass.");

    a_finish_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && slot_free) |=> (result_valid && state_reg == ST_IDLE))
        else $error("Finished sample did not present a result.");

    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_ptr_reg <= IDX_W'(TAPS - 1)) && (rd_ptr_reg <= IDX_W'(TAPS - 1)))
        else $error("Delay line pointer out of range.");

endmodule
